// ===== src/lsd_pkg.sv =====
// Shared types and constants for the LSB stego stream decoder.
// Used by every module under src; no dependencies.
package lsd_pkg;

  localparam int unsigned MaxExtLen  = 16;
  localparam int unsigned XlenW      = $clog2(MaxExtLen + 1);
  localparam int unsigned MagicMax   = 8;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [7:0] DotChar     = 8'h2e;

  // Configuration register indexes
  localparam logic [1:0] CfgHeaderBytes = 2'd0;
  localparam logic [1:0] CfgMagic       = 2'd1;
  localparam logic [1:0] CfgMagicLen    = 2'd2;

  // Result kinds
  localparam logic [1:0] KindExt  = 2'd0;
  localparam logic [1:0] KindData = 2'd1;
  localparam logic [1:0] KindErr  = 2'd2;

  // Error codes
  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrMagicLen = 3'd1;
  localparam logic [2:0] ErrMagic    = 3'd2;
  localparam logic [2:0] ErrExt      = 3'd3;
  localparam logic [2:0] ErrSize     = 3'd4;

  typedef enum logic [2:0] {
    PH_MLEN,
    PH_MAGIC,
    PH_XLEN,
    PH_EXT,
    PH_SIZE,
    PH_DATA,
    PH_DONE
  } phase_e;

  // One classified input beat from front to back.
  typedef struct packed {
    logic restart;
    logic bit_vld;
    logic data_bit;
  } tok_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] error_code;
    logic       last;
  } res_t;

endpackage

// ===== src/lsb_stego_stream_decoder.sv =====
// Top level of the LSB stego stream decoder: config registers and wiring.
// Depends on lsd_pkg, lsd_front, lsd_tok_queue, lsd_back, lsd_res_queue.
//
// The decoder takes one carrier image byte per beat on a queue-style input
// (push/full) and returns decoded results on a queue-style output
// (empty/pop). After skipping header_bytes leading bytes of each image it
// gathers bit 0 of every byte, MSB first, into a 32-bit magic length, the
// magic text (checked against expected_magic/expected_magic_length), a 32-bit
// extension length, the extension text (must start with '.'), a signed 32-bit
// payload size and the payload. Extension characters come out as kind 0,
// payload bytes as kind 1 with last on the final byte, and a failed check as a
// single kind 2 report with last set; further bytes are then dropped until
// start_of_image. Throughput is one byte per clock unless a queue is full:
// the front end does the header skip and hands bit tokens through a 4-deep
// queue to the back end, which updates its field parser once per cycle while
// a token waits and the output queue has room, and writes at most one result
// into a 4-deep output queue; a result passes through both queues before it
// can be popped. Write configuration only while the block is drained.
module lsb_stego_stream_decoder import lsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        push,
  output logic        full,
  input  logic [7:0]  image_byte_i,
  input  logic        start_of_image_i,
  // result beats
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [2:0]  error_code_o,
  output logic        last_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [9:0]  header_bytes_q;
  logic [63:0] expected_magic_q;
  logic [3:0]  expected_magic_len_q;

  logic tok_push, tok_full, tok_empty, tok_pop;
  tok_t tok_wdata, tok_rdata;
  logic res_push, res_full;
  res_t res_wdata, res_rdata;
  logic in_beat;

  // Hold config; ignore writes to unused indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_bytes_q       <= 10'd54;
      expected_magic_q     <= '0;
      expected_magic_len_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeaderBytes: header_bytes_q       <= cfg_data_i[9:0];
        CfgMagic:       expected_magic_q     <= cfg_data_i;
        CfgMagicLen:    expected_magic_len_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Accept a beat only when the token queue has room.
  assign full    = tok_full;
  assign in_beat = push && !tok_full;

  lsd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_beat),
    .image_byte_i    (image_byte_i),
    .start_of_image_i(start_of_image_i),
    .header_bytes_i  (header_bytes_q),
    .tok_push_o      (tok_push),
    .tok_o           (tok_wdata)
  );

  lsd_tok_queue u_tok_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (tok_push),
    .wdata_i(tok_wdata),
    .full_o (tok_full),
    .pop_i  (tok_pop),
    .empty_o(tok_empty),
    .rdata_o(tok_rdata)
  );

  lsd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .tok_empty_i         (tok_empty),
    .tok_i               (tok_rdata),
    .tok_pop_o           (tok_pop),
    .res_full_i          (res_full),
    .res_push_o          (res_push),
    .res_o               (res_wdata),
    .expected_magic_i    (expected_magic_q),
    .expected_magic_len_i(expected_magic_len_q)
  );

  lsd_res_queue u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_wdata),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(res_rdata)
  );

  assign kind_o       = res_rdata.kind;
  assign byte_value_o = res_rdata.byte_value;
  assign error_code_o = res_rdata.error_code;
  assign last_o       = res_rdata.last;

endmodule

// ===== src/lsd_front.sv =====
// Front end: accepts image bytes, skips the header, emits bit tokens.
// Depends on lsd_pkg.
module lsd_front import lsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] image_byte_i,
  input  logic       start_of_image_i,
  input  logic [9:0] header_bytes_i,
  output logic       tok_push_o,
  output tok_t       tok_o
);

  logic       hdr_act_q, hdr_act_d;
  logic [9:0] hdr_cnt_q, hdr_cnt_d;
  logic       act;
  logic [9:0] cnt;

  always_comb begin
    act       = start_of_image_i ? 1'b1 : hdr_act_q;
    cnt       = start_of_image_i ? '0 : hdr_cnt_q;
    hdr_act_d = hdr_act_q;
    hdr_cnt_d = hdr_cnt_q;
    tok_o.restart  = start_of_image_i;
    tok_o.data_bit = image_byte_i[0];
    tok_o.bit_vld  = 1'b1;
    if (act && (cnt < header_bytes_i)) begin
      tok_o.bit_vld = 1'b0;
      hdr_cnt_d     = cnt + 10'd1;
      hdr_act_d     = 1'b1;
    end else begin
      hdr_cnt_d = cnt;
      hdr_act_d = 1'b0;
    end
    // Drop header beats unless they carry a restart.
    tok_push_o = valid_i && (start_of_image_i || tok_o.bit_vld);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_act_q <= 1'b1;
      hdr_cnt_q <= '0;
    end else if (valid_i) begin
      hdr_act_q <= hdr_act_d;
      hdr_cnt_q <= hdr_cnt_d;
    end
  end

endmodule

// ===== src/lsd_tok_queue.sv =====
// Short token queue between front and back end.
// Depends on lsd_pkg.
module lsd_tok_queue import lsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output tok_t rdata_o
);

  tok_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(do_push) - QCntW'(do_pop);
    end
  end

endmodule

// ===== src/lsd_res_queue.sv =====
// Result queue that drives the output side of the decoder.
// Depends on lsd_pkg.
module lsd_res_queue import lsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t rdata_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(do_push) - QCntW'(do_pop);
    end
  end

endmodule

// ===== src/lsd_back.sv =====
// Back end: collects hidden bits into fields, checks them, emits results.
// Depends on lsd_pkg.
module lsd_back import lsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tok_empty_i,
  input  tok_t        tok_i,
  output logic        tok_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output res_t        res_o,
  input  logic [63:0] expected_magic_i,
  input  logic [3:0]  expected_magic_len_i
);

  phase_e           phase_q, phase_d;
  logic [4:0]       bcnt_q, bcnt_d;
  logic [31:0]      shift_q, shift_d;
  logic [30:0]      icnt_q, icnt_d;
  logic [3:0]       mlen_q, mlen_d;
  logic [XlenW-1:0] xlen_q, xlen_d;
  logic [30:0]      psize_q, psize_d;
  logic             mm_q, mm_d;

  logic [31:0] shift_n;
  logic [4:0]  bcnt_n;
  logic [30:0] icnt_n;
  logic [7:0]  ch, want;
  logic        mm_n;

  assign tok_pop_o = !tok_empty_i && !res_full_i;

  always_comb begin
    // Apply a restart before the bit of the same beat.
    phase_d = tok_i.restart ? PH_MLEN : phase_q;
    bcnt_d  = tok_i.restart ? '0 : bcnt_q;
    shift_d = tok_i.restart ? '0 : shift_q;
    icnt_d  = tok_i.restart ? '0 : icnt_q;
    mlen_d  = tok_i.restart ? '0 : mlen_q;
    xlen_d  = tok_i.restart ? '0 : xlen_q;
    psize_d = tok_i.restart ? '0 : psize_q;
    mm_d    = tok_i.restart ? 1'b1 : mm_q;

    res_push_o       = 1'b0;
    res_o.kind       = KindExt;
    res_o.byte_value = '0;
    res_o.error_code = ErrNone;
    res_o.last       = 1'b0;

    shift_n = {shift_d[30:0], tok_i.data_bit};
    bcnt_n  = bcnt_d + 5'd1;
    icnt_n  = icnt_d + 31'd1;
    ch      = shift_n[7:0];
    want    = expected_magic_i[{icnt_d[2:0], 3'b000} +: 8];
    mm_n    = mm_d && (ch == want);

    if (tok_pop_o && tok_i.bit_vld && (phase_d != PH_DONE)) begin
      case (phase_d)
        PH_MLEN, PH_XLEN, PH_SIZE: begin
          shift_d = shift_n;
          bcnt_d  = bcnt_n;
          if (bcnt_n == '0) begin
            shift_d = '0;
            icnt_d  = '0;
            case (phase_d)
              PH_MLEN: begin
                if (shift_n == '0) begin
                  res_push_o       = 1'b1;
                  res_o.error_code = ErrMagicLen;
                end else if (shift_n > 32'(MagicMax) ||
                             shift_n != {28'd0, expected_magic_len_i}) begin
                  res_push_o       = 1'b1;
                  res_o.error_code = ErrMagic;
                end else begin
                  mlen_d  = shift_n[3:0];
                  mm_d    = 1'b1;
                  phase_d = PH_MAGIC;
                end
              end
              PH_XLEN: begin
                if (shift_n == '0 || shift_n > 32'(MaxExtLen)) begin
                  res_push_o       = 1'b1;
                  res_o.error_code = ErrExt;
                end else begin
                  xlen_d  = shift_n[XlenW-1:0];
                  phase_d = PH_EXT;
                end
              end
              default: begin
                if (shift_n == '0 || shift_n[31]) begin
                  res_push_o       = 1'b1;
                  res_o.error_code = ErrSize;
                end else begin
                  psize_d = shift_n[30:0];
                  phase_d = PH_DATA;
                end
              end
            endcase
          end
        end
        default: begin
          shift_d = shift_n;
          bcnt_d  = bcnt_n;
          if (bcnt_n >= 5'd8) begin
            bcnt_d  = '0;
            shift_d = '0;
            case (phase_d)
              PH_MAGIC: begin
                mm_d   = mm_n;
                icnt_d = icnt_n;
                if (icnt_n >= 31'(mlen_d)) begin
                  if (!mm_n) begin
                    res_push_o       = 1'b1;
                    res_o.error_code = ErrMagic;
                  end else begin
                    phase_d = PH_XLEN;
                  end
                end
              end
              PH_EXT: begin
                if (icnt_d == '0 && ch != DotChar) begin
                  res_push_o       = 1'b1;
                  res_o.error_code = ErrExt;
                end else begin
                  icnt_d           = icnt_n;
                  res_push_o       = 1'b1;
                  res_o.kind       = KindExt;
                  res_o.byte_value = ch;
                  if (icnt_n >= 31'(xlen_d)) phase_d = PH_SIZE;
                end
              end
              default: begin
                icnt_d           = icnt_n;
                res_push_o       = 1'b1;
                res_o.kind       = KindData;
                res_o.byte_value = ch;
                if (icnt_n >= psize_d) begin
                  res_o.last = 1'b1;
                  phase_d    = PH_DONE;
                end
              end
            endcase
          end
        end
      endcase
      // Any error report ends the parse.
      if (res_o.error_code != ErrNone) begin
        res_o.kind = KindErr;
        res_o.last = 1'b1;
        phase_d    = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MLEN;
      bcnt_q  <= '0;
      shift_q <= '0;
      icnt_q  <= '0;
      mlen_q  <= '0;
      xlen_q  <= '0;
      psize_q <= '0;
      mm_q    <= 1'b1;
    end else if (tok_pop_o) begin
      phase_q <= phase_d;
      bcnt_q  <= bcnt_d;
      shift_q <= shift_d;
      icnt_q  <= icnt_d;
      mlen_q  <= mlen_d;
      xlen_q  <= xlen_d;
      psize_q <= psize_d;
      mm_q    <= mm_d;
    end
  end

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.kind == KindErr |-> res_o.last && res_o.error_code != ErrNone)
    else $error("error report without last or code");

  a_data_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.kind != KindErr |-> res_o.error_code == ErrNone)
    else $error("data result carries an error code");

  a_res_from_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> tok_pop_o && !res_full_i)
    else $error("result pushed without a consumed token");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.last |=> phase_q == PH_DONE)
    else $error("parse continues after a last result");

endmodule
